// ----- sv/mtbs_pkg.sv -----
package mtbs_pkg;

  localparam int MT_N     = 624;
  localparam int MT_SHIFT = 30;
  localparam int POS_W    = 10;
  localparam int CNT_W    = 6;

  localparam logic [31:0] MT_INIT_MULT = 32'd1812433253;
  localparam logic [31:0] MT_MATRIX    = 32'h9908b0df;
  localparam logic [31:0] MT_UPPER     = 32'h80000000;
  localparam logic [31:0] MT_LOWER     = 32'h7fffffff;
  localparam logic [31:0] SEED_RESET   = 32'd5489;

  localparam logic [POS_W-1:0] POS_END   = 10'd624;
  localparam logic [POS_W-1:0] LAST_IDX  = 10'd623;
  localparam logic [POS_W-1:0] FAR_START = 10'd397;

  localparam logic [2:0] VB_WORD = 3'd4;
  localparam logic [2:0] VB_BYTE = 3'd1;
  localparam logic [2:0] VB_NONE = 3'd0;

  localparam logic REQ_GEN  = 1'b0;
  localparam logic REQ_SEED = 1'b1;

  typedef enum logic [1:0] {
    OP_DRAW = 2'd0,
    OP_SEED = 2'd1,
    OP_ACK  = 2'd2
  } mtbs_op_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] byte_count;
  } mtbs_in_t;

  typedef struct packed {
    logic [31:0] random_word;
    logic [2:0]  valid_bytes;
    logic        last_result;
  } mtbs_out_t;

  typedef struct packed {
    mtbs_op_t         op;
    logic [CNT_W-1:0] words;
    logic [CNT_W-1:0] total;
  } mtbs_cmd_t;

endpackage

// ----- sv/mtbs_front.sv -----
module mtbs_front #(
  parameter int MAX_REQUEST_BYTES = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mtbs_pkg::mtbs_in_t   in_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  output mtbs_pkg::mtbs_cmd_t  cmd,
  output logic                 cmd_valid,
  input  logic                 cmd_pop
);
  import mtbs_pkg::*;

  localparam logic [7:0] MAX_CNT = 8'(MAX_REQUEST_BYTES);

  mtbs_cmd_t  cls;
  logic [7:0] cnt_sat;
  mtbs_cmd_t  q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic [1:0] fill_nxt;
  logic       push;

  // classify: reseed, zero-count acknowledge, or draw run
  always_comb begin
    cnt_sat   = (in_data.byte_count > MAX_CNT) ? MAX_CNT : in_data.byte_count;
    cls.words = cnt_sat[7:2];
    cls.total = cnt_sat[7:2] + {{(CNT_W-2){1'b0}}, cnt_sat[1:0]};
    if (in_data.req_type == REQ_SEED) begin
      cls.op = OP_SEED;
    end else if (cnt_sat == 8'd0) begin
      cls.op = OP_ACK;
    end else begin
      cls.op = OP_DRAW;
    end
  end

  assign in_ready  = (fill_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !cmd_pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (!push && cmd_pop) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (cmd_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ----- sv/mtbs_engine.sv -----
module mtbs_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [31:0]          seed,
  input  mtbs_pkg::mtbs_cmd_t  cmd,
  input  logic                 cmd_valid,
  output logic                 cmd_pop,
  output mtbs_pkg::mtbs_out_t  out_data,
  output logic                 out_valid,
  input  logic                 out_ready
);
  import mtbs_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b00000001,
    S_FILL0   = 8'b00000010,
    S_FILL    = 8'b00000100,
    S_TWPRIME = 8'b00001000,
    S_TWLOAD  = 8'b00010000,
    S_TWRUN   = 8'b00100000,
    S_DRAW    = 8'b01000000,
    S_ACK     = 8'b10000000
  } state_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  state_t           state_r;
  state_t           state_nxt;
  logic [31:0]      mem [MT_N];
  logic [31:0]      rd_a_r;
  logic [31:0]      rd_b_r;
  logic [31:0]      cur_r;
  logic [31:0]      p_r;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] k_r;
  logic [POS_W-1:0] na_r;
  logic [POS_W-1:0] fb_r;
  logic [POS_W-1:0] na_inc;
  logic [POS_W-1:0] fb_inc;
  logic             boot_r;
  logic [CNT_W-1:0] rem_r;
  logic [CNT_W-1:0] words_r;
  logic             pending_r;
  logic [2:0]       pend_vb_r;
  logic             pend_last_r;
  mtbs_out_t        out_r;
  logic             out_valid_r;

  logic             slot_free;
  logic             move;
  logic             ack_fire;
  logic             issue;
  logic [31:0]      fill_mix;
  logic [31:0]      fill_word;
  logic [31:0]      tw_y;
  logic [31:0]      tw_word;

  logic             we;
  logic [POS_W-1:0] waddr;
  logic [31:0]      wdata;
  logic             re_a;
  logic [POS_W-1:0] raddr_a;
  logic             re_b;
  logic [POS_W-1:0] raddr_b;

  assign slot_free = !out_valid_r || out_ready;
  assign move      = pending_r && slot_free;
  assign ack_fire  = (state_r == S_ACK) && !pending_r && slot_free;
  assign issue     = (state_r == S_DRAW) && (pos_r != POS_END) && (!pending_r || move);
  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid;

  assign fill_mix  = p_r ^ (p_r >> MT_SHIFT);
  assign fill_word = fill_mix * MT_INIT_MULT + {22'b0, k_r};

  assign tw_y    = (cur_r & MT_UPPER) | (rd_a_r & MT_LOWER);
  assign tw_word = rd_b_r ^ (tw_y >> 1) ^ (tw_y[0] ? MT_MATRIX : 32'd0);

  assign na_inc = (na_r == LAST_IDX) ? '0 : na_r + 10'd1;
  assign fb_inc = (fb_r == LAST_IDX) ? '0 : fb_r + 10'd1;

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  // state memory ports
  always_comb begin
    we      = 1'b0;
    waddr   = k_r;
    wdata   = fill_word;
    re_a    = 1'b0;
    raddr_a = pos_r;
    re_b    = 1'b0;
    raddr_b = fb_inc;
    case (state_r)
      S_FILL0: begin
        we    = 1'b1;
        waddr = '0;
        wdata = seed;
      end
      S_FILL: begin
        we = 1'b1;
      end
      S_TWPRIME: begin
        re_a    = 1'b1;
        raddr_a = '0;
      end
      S_TWLOAD: begin
        re_a    = 1'b1;
        raddr_a = 10'd1;
        re_b    = 1'b1;
        raddr_b = FAR_START;
      end
      S_TWRUN: begin
        we      = 1'b1;
        wdata   = tw_word;
        re_a    = 1'b1;
        raddr_a = na_inc;
        re_b    = 1'b1;
      end
      S_DRAW: begin
        re_a = issue;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_SEED: state_nxt = S_FILL0;
            OP_ACK:  state_nxt = S_ACK;
            default: state_nxt = S_DRAW;
          endcase
        end
      end
      S_FILL0: state_nxt = S_FILL;
      S_FILL: begin
        if (k_r == LAST_IDX) begin
          state_nxt = boot_r ? S_IDLE : S_ACK;
        end
      end
      S_TWPRIME: state_nxt = S_TWLOAD;
      S_TWLOAD:  state_nxt = S_TWRUN;
      S_TWRUN: begin
        if (k_r == LAST_IDX) begin
          state_nxt = S_DRAW;
        end
      end
      S_DRAW: begin
        // twist reuses the read register, so wait for the pending draw to leave
        if (pos_r == POS_END && !pending_r) begin
          state_nxt = S_TWPRIME;
        end else if (issue && rem_r == 6'd1) begin
          state_nxt = S_IDLE;
        end
      end
      S_ACK: begin
        if (ack_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL0;
      pos_r       <= POS_END;
      boot_r      <= 1'b1;
      k_r         <= '0;
      na_r        <= '0;
      fb_r        <= '0;
      rem_r       <= '0;
      words_r     <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (cmd_valid && cmd.op == OP_DRAW) begin
            rem_r   <= cmd.total;
            words_r <= cmd.words;
          end
        end
        S_FILL0: k_r <= 10'd1;
        S_FILL: begin
          k_r <= k_r + 10'd1;
          if (k_r == LAST_IDX) begin
            pos_r  <= POS_END;
            boot_r <= 1'b0;
          end
        end
        S_TWLOAD: begin
          k_r  <= '0;
          na_r <= 10'd1;
          fb_r <= FAR_START;
        end
        S_TWRUN: begin
          k_r  <= k_r + 10'd1;
          na_r <= na_inc;
          fb_r <= fb_inc;
          if (k_r == LAST_IDX) begin
            pos_r <= '0;
          end
        end
        default: begin
        end
      endcase
      if (issue) begin
        pos_r <= pos_r + 10'd1;
        rem_r <= rem_r - 6'd1;
        if (words_r != '0) begin
          words_r <= words_r - 6'd1;
        end
      end
      if (issue) begin
        pending_r <= 1'b1;
      end else if (move) begin
        pending_r <= 1'b0;
      end
      if (move || ack_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_FILL0:  p_r   <= seed;
      S_FILL:   p_r   <= fill_word;
      S_TWLOAD: cur_r <= rd_a_r;
      S_TWRUN:  cur_r <= rd_a_r;
      default: begin
      end
    endcase
    if (issue) begin
      pend_vb_r   <= (words_r != '0) ? VB_WORD : VB_BYTE;
      pend_last_r <= (rem_r == 6'd1);
    end
    if (move) begin
      out_r.random_word <= temper(rd_a_r);
      out_r.valid_bytes <= pend_vb_r;
      out_r.last_result <= pend_last_r;
    end else if (ack_fire) begin
      out_r.random_word <= '0;
      out_r.valid_bytes <= VB_NONE;
      out_r.last_result <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rd_a_r <= mem[raddr_a];
    end
    if (re_b) begin
      rd_b_r <= mem[raddr_b];
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_END)
    else $error("read position beyond state size");

  a_no_pending_in_twist: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TWRUN || state_r == S_TWLOAD) |-> !pending_r)
    else $error("draw pending while twist uses the read register");

  a_twist_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TWRUN && k_r == LAST_IDX) |=> (pos_r == '0 && state_r == S_DRAW))
    else $error("twist did not rewind the read position");

  a_fill_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL && k_r == LAST_IDX) |=> (pos_r == POS_END && !boot_r))
    else $error("fill did not leave the position at the end");

endmodule

// ----- sv/mersenne_twister_byte_source.sv -----
// Path: a request waits in the front queue; the engine reads a state word into the read register
// and the output register holds the tempered draw. Throughput, set by the state memory read port:
// one draw per cycle within a request while results are taken; every 624 draws a twist pass
// (one state word per cycle) stalls draws. A reseed refills the state, then acknowledges.
// Reset sets the seed register to 5489 and runs the same fill; up to two requests queue meanwhile.
module mersenne_twister_byte_source #(
  parameter int MAX_REQUEST_BYTES = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mtbs_pkg::mtbs_in_t   in_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  output mtbs_pkg::mtbs_out_t  out_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import mtbs_pkg::*;

  logic [31:0] seed_r;
  mtbs_cmd_t   cmd;
  logic        cmd_valid;
  logic        cmd_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? seed_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      seed_r <= pwdata;
    end
  end

  mtbs_front #(
    .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  mtbs_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .seed      (seed_r),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

// ----- dv/mtbs_draw_checker.sv -----
`timescale 1ns / 1ps

module mtbs_draw_checker #(
  parameter int MAX_REQUEST_BYTES = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mtbs_pkg::mtbs_in_t   in_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  mtbs_pkg::mtbs_out_t  out_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  input  logic                 pready,
  output int                   mismatch_count,
  output int                   results_pending
);
  import mtbs_pkg::*;

  localparam int REG_SEED = 0;

  logic [31:0] seed_reg;
  logic [31:0] state_words [MT_N];
  int unsigned draw_pos;
  mtbs_out_t   expected_results [$];

  function automatic void seed_state(input logic [31:0] seed);
    logic [31:0] prev;
    state_words[0] = seed;
    for (int k = 1; k < MT_N; k++) begin
      prev = state_words[k-1];
      state_words[k] = MT_INIT_MULT * (prev ^ (prev >> MT_SHIFT)) + 32'(k);
    end
    draw_pos = MT_N;
  endfunction

  function automatic void twist_state();
    logic [31:0] y;
    logic [31:0] v;
    int nxt;
    int far_idx;
    for (int k = 0; k < MT_N; k++) begin
      nxt     = (k + 1) % MT_N;
      far_idx = (k + int'(FAR_START)) % MT_N;
      y = (state_words[k] & MT_UPPER) | (state_words[nxt] & MT_LOWER);
      v = state_words[far_idx] ^ (y >> 1);
      if (y[0]) begin
        v = v ^ MT_MATRIX;
      end
      state_words[k] = v;
    end
    draw_pos = 0;
  endfunction

  function automatic logic [31:0] next_tempered_draw();
    logic [31:0] y;
    if (draw_pos >= MT_N) begin
      twist_state();
    end
    y = state_words[draw_pos];
    draw_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic void predict_request(input mtbs_in_t req);
    mtbs_out_t res;
    int count;
    int words;
    int total;
    res.random_word = '0;
    res.valid_bytes = VB_NONE;
    res.last_result = 1'b1;
    if (req.req_type == REQ_SEED) begin
      seed_state(seed_reg);
      expected_results.push_back(res);
      return;
    end
    count = (req.byte_count > MAX_REQUEST_BYTES) ? MAX_REQUEST_BYTES : int'(req.byte_count);
    // zero-length request still gets a single acknowledge
    if (count == 0) begin
      expected_results.push_back(res);
      return;
    end
    words = count / 4;
    total = words + count % 4;
    for (int i = 0; i < total; i++) begin
      res.random_word = next_tempered_draw();
      res.valid_bytes = (i < words) ? VB_WORD : VB_BYTE;
      res.last_result = (i == total - 1);
      expected_results.push_back(res);
    end
  endfunction

  always @(posedge clk) begin : watch
    mtbs_out_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      seed_reg = SEED_RESET;
      seed_state(SEED_RESET);
      expected_results.delete();
    end else begin
      // check results before predicting, a new request never matches this edge
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: random_word %h valid_bytes %0d last_result %0d",
                 out_data.random_word, out_data.valid_bytes, out_data.last_result);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.random_word !== want.random_word) begin
            $error("random_word: expected %h, got %h", want.random_word, out_data.random_word);
            errs++;
          end
          if (out_data.valid_bytes !== want.valid_bytes) begin
            $error("valid_bytes: expected %0d, got %0d", want.valid_bytes, out_data.valid_bytes);
            errs++;
          end
          if (out_data.last_result !== want.last_result) begin
            $error("last_result: expected %0d, got %0d", want.last_result, out_data.last_result);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_request(in_data);
      end
      if (psel && penable && pwrite && pready && int'(paddr >> 2) == REG_SEED) begin
        seed_reg = pwdata;
      end
    end
    mismatch_count  <= mismatch_count + errs;
    results_pending <= expected_results.size();
  end

endmodule

// ----- dv/tb_mersenne_twister_byte_source.sv -----
`timescale 1ns / 1ps

module tb_mersenne_twister_byte_source;
  import mtbs_pkg::*;

  localparam int          MAX_BYTES   = 128;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam logic [2:0]  ADDR_SEED   = 3'd0;
  localparam logic [2:0]  ADDR_UNUSED = 3'd4;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  mtbs_in_t    in_data   = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  mtbs_out_t   out_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;
  int          mismatch_count;
  int          results_pending;
  int          burst_left = 0;

  always #4 clk = ~clk;

  mersenne_twister_byte_source #(
    .MAX_REQUEST_BYTES(MAX_BYTES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_data (out_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  mtbs_draw_checker #(
    .MAX_REQUEST_BYTES(MAX_BYTES)
  ) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_data        (in_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_data       (out_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  // receiver: alternate between always-ready, random stalls and periodic stall bursts
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned hold;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(32, 400);
      hold = $urandom_range(1, 12);
      case (mode)
        0: begin
          out_ready <= 1'b1;
          repeat (span) @(posedge clk);
        end
        1: begin
          repeat (span) begin
            out_ready <= ($urandom_range(0, 2) != 0);
            @(posedge clk);
          end
        end
        default: begin
          for (int i = 0; i < span; i++) begin
            out_ready <= ((i % (hold + 4)) >= hold);
            @(posedge clk);
          end
        end
      endcase
    end
  end

  task automatic send_request(input logic req, input logic [7:0] count);
    // drop valid for a gap between bursts, never raise it again in the same step
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_data  <= '{req_type: req, byte_count: count};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] random_count();
    case ($urandom_range(0, 15))
      0:          return 8'd0;
      1:          return 8'($urandom_range(129, 255));
      2, 3, 4, 5: return 8'($urandom_range(17, 128));
      default:    return 8'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic random_requests(input int n);
    for (int i = 0; i < n; i++) begin
      send_request(($urandom_range(0, 23) == 0) ? REQ_SEED : REQ_GEN, random_count());
    end
  endtask

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_mersenne_twister_byte_source: FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] seeds [4];
    seeds[0] = 32'd0;
    seeds[1] = 32'hffffffff;
    seeds[2] = $urandom();
    seeds[3] = 32'h80000000;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset seed: edge counts, zero and oversized requests, reseeds
    send_request(REQ_GEN, 8'd4);
    send_request(REQ_GEN, 8'd1);
    send_request(REQ_GEN, 8'd2);
    send_request(REQ_GEN, 8'd3);
    send_request(REQ_GEN, 8'd5);
    send_request(REQ_GEN, 8'd0);
    send_request(REQ_GEN, 8'd128);
    send_request(REQ_GEN, 8'd129);
    send_request(REQ_GEN, 8'd255);
    send_request(REQ_SEED, 8'd0);
    send_request(REQ_GEN, 8'd7);
    send_request(REQ_SEED, 8'd255);
    send_request(REQ_GEN, 8'd127);
    send_request(REQ_GEN, 8'd64);
    send_request(REQ_GEN, 8'd170);
    drain_results();

    for (int p = 0; p < 4; p++) begin
      apb_write(ADDR_SEED, seeds[p]);
      // a write to an unmapped register must leave the seed alone
      if (p == 2) begin
        @(posedge clk);
        apb_write(ADDR_UNUSED, $urandom());
      end
      send_request(REQ_SEED, random_count());
      random_requests(80);
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("tb_mersenne_twister_byte_source: PASS");
    end else begin
      $display("tb_mersenne_twister_byte_source: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/mtbs_pkg.sv
sv/mtbs_front.sv
sv/mtbs_engine.sv
sv/mersenne_twister_byte_source.sv
dv/mtbs_draw_checker.sv
dv/tb_mersenne_twister_byte_source.sv
